/* rtl/fresnel_dielectric_reflectance_defines.svh */
// Assertion macros for the dielectric Fresnel reflectance block.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_DEFINES_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_DEFINES_SVH

`ifndef SYNTHESIS
`define FDR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdr: same-cycle check failed");
`define FDR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdr: next-cycle check failed");
`else
`define FDR_ASSERT_IMPL(lbl, ante, cons)
`define FDR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/fdr_pkg.sv */
// Shared types and constants for the dielectric Fresnel reflectance block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fdr_pkg;

    localparam int IDX_W       = 16;
    localparam int COS_W       = 16;
    localparam int CM_W        = 15;
    localparam int ONE_Q14     = 16384;
    localparam int SQRT_RAD_W  = 62;
    localparam int SQRT_ROOT_W = 31;

    typedef enum logic {
        REG_INDEX_INCIDENT    = 1'b0,
        REG_INDEX_TRANSMITTED = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [IDX_W-1:0] ei;
        logic [IDX_W-1:0] et;
        logic [CM_W-1:0]  cm;
        logic             tir;
    } side_t;

endpackage
`default_nettype wire

/* rtl/fdr_isqrt.sv */
// Pipelined integer square root, one root bit per stage, with sideband.
// Depends on fdr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fdr_isqrt (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [fdr_pkg::SQRT_RAD_W-1:0]       in_rad,
    input  fdr_pkg::side_t                       in_side,
    output logic                                 out_valid,
    output logic [fdr_pkg::SQRT_ROOT_W-1:0]      out_root,
    output fdr_pkg::side_t                       out_side
);
    import fdr_pkg::*;

    localparam int STEPS = SQRT_ROOT_W;
    localparam int REM_W = SQRT_ROOT_W + 3;

    logic                   v_reg    [STEPS];
    logic [REM_W-1:0]       rem_reg  [STEPS];
    logic [STEPS-1:0]       root_reg [STEPS];
    logic [SQRT_RAD_W-1:0]  rad_reg  [STEPS];
    side_t                  side_reg [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic                  v_prev;
        logic [REM_W-1:0]      rem_prev;
        logic [STEPS-1:0]      root_prev;
        logic [SQRT_RAD_W-1:0] rad_prev;
        side_t                 side_prev;
        logic [REM_W-1:0]      rem_sh;
        logic [REM_W-1:0]      trial;
        logic                  ge;
        logic [REM_W-1:0]      rem_next;

        if (s == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = in_rad;
            assign side_prev = in_side;
        end
        else begin : g_rest
            assign v_prev    = v_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign root_prev = root_reg[s-1];
            assign rad_prev  = rad_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        assign rem_sh   = {rem_prev[REM_W-3:0], rad_prev[SQRT_RAD_W-1 -: 2]};
        assign trial    = {{(REM_W-STEPS-2){1'b0}}, root_prev, 2'b01};
        assign ge       = rem_sh >= trial;
        assign rem_next = ge ? rem_sh - trial : rem_sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= {root_prev[STEPS-2:0], ge};
                rad_reg[s]  <= {rad_prev[SQRT_RAD_W-3:0], 2'b00};
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

/* rtl/fresnel_dielectric_reflectance.sv */
// Top level: unpolarized dielectric Fresnel reflectance, fully pipelined.
// Depends on fdr_pkg, fdr_isqrt and fresnel_dielectric_reflectance_defines.svh.
//
//   channel | signals                                   | flow
//   cfg     | cfg_write_en, cfg_index, cfg_data         | write only
//   in      | in_valid, in_stall, cos_incident          | one item per cycle
//   out     | out_valid, out_stall, reflectance, total_reflection | one item per cycle
//
// One item per cycle while the output is not held; depth is set by the
// bit-per-stage square roots (31 stages each), the refracted-sine divide (30)
// and the two amplitude ratio divides (30, side by side).
// Reset clears all valid bits and loads the indices 1.0 and 1.5.
// A held output freezes the whole pipe; in_stall follows it in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "fresnel_dielectric_reflectance_defines.svh"
module fresnel_dielectric_reflectance #(
    parameter int RESULT_FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  fdr_pkg::cfg_index_t               cfg_index,
    input  logic [fdr_pkg::IDX_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [fdr_pkg::COS_W-1:0]  cos_incident,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [RESULT_FRAC_BITS:0]         reflectance,
    output logic                              total_reflection
);
    import fdr_pkg::*;

    localparam int F         = RESULT_FRAC_BITS;
    localparam int REFL_W    = F + 1;
    localparam int DIV_STEPS = 30;
    localparam int RAT_STEPS = 30;
    localparam int PROD_W    = 47;
    localparam int SUM_W     = 48;
    localparam int RAT_W     = 31;
    localparam int SQ_W      = 62;
    localparam int ACC_W     = 63;
    localparam logic [REFL_W-1:0] REFL_ONE = REFL_W'(1) << F;
    localparam logic signed [16:0] C_MAX = 17'(ONE_Q14);
    localparam logic signed [16:0] C_MIN = -17'(ONE_Q14);

    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // configuration
    logic [IDX_W-1:0] index_incident_side_reg;
    logic [IDX_W-1:0] index_transmitted_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_incident_side_reg    <= 16'd4096;
            index_transmitted_side_reg <= 16'd6144;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_INDEX_INCIDENT:    index_incident_side_reg    <= cfg_data;
                REG_INDEX_TRANSMITTED: index_transmitted_side_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // S0: clamp, orient
    logic signed [16:0] c_ext;
    logic signed [16:0] c_clamp;
    logic               c_pos;
    logic [16:0]        c_mag;
    side_t              s0_side_next;
    logic               s0_v_reg;
    side_t              s0_side_reg;

    assign c_ext   = 17'(cos_incident);
    assign c_clamp = (c_ext > C_MAX) ? C_MAX : ((c_ext < C_MIN) ? C_MIN : c_ext);
    assign c_pos   = c_clamp > 17'sd0;
    assign c_mag   = c_pos ? c_clamp : -c_clamp;

    always_comb
    begin
        s0_side_next.ei  = c_pos ? index_incident_side_reg : index_transmitted_side_reg;
        s0_side_next.et  = c_pos ? index_transmitted_side_reg : index_incident_side_reg;
        s0_side_next.cm  = c_mag[CM_W-1:0];
        s0_side_next.tir = 1'b0;
    end

    // S1: 1 - cos^2 in Q28
    logic [29:0] s1_sq;
    logic [29:0] s1_x_next;
    logic        s1_v_reg;
    logic [28:0] s1_x_reg;
    side_t       s1_side_reg;

    assign s1_sq     = 30'(s0_side_reg.cm) * 30'(s0_side_reg.cm);
    assign s1_x_next = (30'd1 << 28) - s1_sq;

    // sine of incidence
    logic                   sq1_valid;
    logic [SQRT_ROOT_W-1:0] sq1_root;
    side_t                  sq1_side;

    fdr_isqrt u_sqrt_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_v_reg),
        .in_rad    ({1'b0, s1_x_reg, 32'b0}),
        .in_side   (s1_side_reg),
        .out_valid (sq1_valid),
        .out_root  (sq1_root),
        .out_side  (sq1_side)
    );

    // S2: ei * sin_i
    logic              s2_v_reg;
    logic [PROD_W-1:0] s2_num_reg;
    side_t             s2_side_reg;

    // S3: TIR test, divide setup
    logic [PROD_W-1:0] s3_lim;
    side_t             s3_side_next;
    logic              s3_v_reg;
    logic [15:0]       s3_rem_reg;
    logic [29:0]       s3_low_reg;
    side_t             s3_side_reg;

    assign s3_lim = {1'b0, s2_side_reg.et, 30'b0};

    always_comb
    begin
        s3_side_next     = s2_side_reg;
        s3_side_next.tir = s2_num_reg >= s3_lim;
    end

    // refracted sine: num / et
    logic        dv_v_reg    [DIV_STEPS];
    logic [15:0] dv_rem_reg  [DIV_STEPS];
    logic [29:0] dv_q_reg    [DIV_STEPS];
    logic [29:0] dv_low_reg  [DIV_STEPS];
    side_t       dv_side_reg [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        logic        v_prev;
        logic [15:0] rem_prev;
        logic [29:0] q_prev;
        logic [29:0] low_prev;
        side_t       side_prev;
        logic [16:0] r2;
        logic        ge;
        logic [16:0] rem_next;

        if (s == 0) begin : g_first
            assign v_prev    = s3_v_reg;
            assign rem_prev  = s3_rem_reg;
            assign q_prev    = '0;
            assign low_prev  = s3_low_reg;
            assign side_prev = s3_side_reg;
        end
        else begin : g_rest
            assign v_prev    = dv_v_reg[s-1];
            assign rem_prev  = dv_rem_reg[s-1];
            assign q_prev    = dv_q_reg[s-1];
            assign low_prev  = dv_low_reg[s-1];
            assign side_prev = dv_side_reg[s-1];
        end

        assign r2       = {rem_prev, low_prev[29]};
        assign ge       = r2 >= {1'b0, side_prev.et};
        assign rem_next = ge ? r2 - {1'b0, side_prev.et} : r2;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[s]  <= rem_next[15:0];
                dv_q_reg[s]    <= {q_prev[28:0], ge};
                dv_low_reg[s]  <= {low_prev[28:0], 1'b0};
                dv_side_reg[s] <= side_prev;
            end
        end
    end

    // S4: sin_t^2, S5: 1 - sin_t^2
    logic        s4_v_reg;
    logic [59:0] s4_sq_reg;
    side_t       s4_side_reg;
    logic        s5_v_reg;
    logic [SQRT_RAD_W-1:0] s5_rad_reg;
    side_t       s5_side_reg;

    logic                   sq2_valid;
    logic [SQRT_ROOT_W-1:0] sq2_root;
    side_t                  sq2_side;

    fdr_isqrt u_sqrt_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_v_reg),
        .in_rad    (s5_rad_reg),
        .in_side   (s5_side_reg),
        .out_valid (sq2_valid),
        .out_root  (sq2_root),
        .out_side  (sq2_side)
    );

    // S6: products et*cI, ei*cT, ei*cI, et*cT
    logic [30:0]       s6_ci;
    logic              s6_v_reg;
    logic [PROD_W-1:0] s6_a_reg [4];
    side_t             s6_side_reg;

    assign s6_ci = {sq2_side.cm, 16'b0};

    // S7: |n| and d per polarization, S8: leading quotient bit
    logic             s7_v_reg;
    logic [SUM_W-1:0] s7_n_reg [2];
    logic [SUM_W-1:0] s7_d_reg [2];
    side_t            s7_side_reg;
    logic             s8_v_reg;
    logic [SUM_W-1:0] s8_r_reg  [2];
    logic [SUM_W-1:0] s8_d_reg  [2];
    logic [RAT_W-1:0] s8_q_reg  [2];
    logic             s8_dz_reg [2];
    side_t            s8_side_reg;

    // amplitude ratios, two lanes
    logic             rt_v_reg    [RAT_STEPS];
    logic [SUM_W-1:0] rt_r_reg    [RAT_STEPS][2];
    logic [SUM_W-1:0] rt_d_reg    [RAT_STEPS][2];
    logic [RAT_W-1:0] rt_q_reg    [RAT_STEPS][2];
    logic             rt_dz_reg   [RAT_STEPS][2];
    side_t            rt_side_reg [RAT_STEPS];

    for (genvar s = 0; s < RAT_STEPS; s++) begin : g_rat
        logic  v_prev;
        side_t side_prev;

        if (s == 0) begin : g_first
            assign v_prev    = s8_v_reg;
            assign side_prev = s8_side_reg;
        end
        else begin : g_rest
            assign v_prev    = rt_v_reg[s-1];
            assign side_prev = rt_side_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                rt_v_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_side_reg[s] <= side_prev;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [SUM_W-1:0] r_prev;
            logic [SUM_W-1:0] d_prev;
            logic [RAT_W-1:0] q_prev;
            logic             dz_prev;
            logic [SUM_W:0]   r2;
            logic             ge;
            logic [SUM_W:0]   r_next;

            if (s == 0) begin : g_first
                assign r_prev  = s8_r_reg[l];
                assign d_prev  = s8_d_reg[l];
                assign q_prev  = s8_q_reg[l];
                assign dz_prev = s8_dz_reg[l];
            end
            else begin : g_rest
                assign r_prev  = rt_r_reg[s-1][l];
                assign d_prev  = rt_d_reg[s-1][l];
                assign q_prev  = rt_q_reg[s-1][l];
                assign dz_prev = rt_dz_reg[s-1][l];
            end

            assign r2     = {r_prev, 1'b0};
            assign ge     = r2 >= {1'b0, d_prev};
            assign r_next = ge ? r2 - {1'b0, d_prev} : r2;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rt_r_reg[s][l]  <= r_next[SUM_W-1:0];
                    rt_d_reg[s][l]  <= d_prev;
                    rt_q_reg[s][l]  <= {q_prev[RAT_W-2:0], ge};
                    rt_dz_reg[s][l] <= dz_prev;
                end
            end
        end
    end

    // S9: squares, S10: sum with rounding, S11: scale and saturate
    logic [RAT_W-1:0] s9_amp [2];
    logic             s9_v_reg;
    logic [SQ_W-1:0]  s9_sq_reg [2];
    side_t            s9_side_reg;
    logic             s10_v_reg;
    logic [ACC_W-1:0] s10_sum_reg;
    logic             s10_tir_reg;
    logic [ACC_W-1:0] s11_shift;
    logic [REFL_W-1:0] refl_next;
    logic [REFL_W-1:0] reflectance_reg;
    logic              total_reflection_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            s9_amp[l] = rt_dz_reg[RAT_STEPS-1][l] ? (RAT_W'(1) << 30)
                                                  : rt_q_reg[RAT_STEPS-1][l];
        end
    end

    assign s11_shift = s10_sum_reg >> (61 - F);
    assign refl_next = (s11_shift > ACC_W'(REFL_ONE)) ? REFL_ONE : s11_shift[REFL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg      <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            s6_v_reg      <= 1'b0;
            s7_v_reg      <= 1'b0;
            s8_v_reg      <= 1'b0;
            s9_v_reg      <= 1'b0;
            s10_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg      <= in_valid;
            s1_v_reg      <= s0_v_reg;
            s2_v_reg      <= sq1_valid;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= dv_v_reg[DIV_STEPS-1];
            s5_v_reg      <= s4_v_reg;
            s6_v_reg      <= sq2_valid;
            s7_v_reg      <= s6_v_reg;
            s8_v_reg      <= s7_v_reg;
            s9_v_reg      <= rt_v_reg[RAT_STEPS-1];
            s10_v_reg     <= s9_v_reg;
            out_valid_reg <= s10_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_side_reg <= s0_side_next;

            s1_x_reg    <= s1_x_next[28:0];
            s1_side_reg <= s0_side_reg;

            s2_num_reg  <= PROD_W'(sq1_side.ei) * PROD_W'(sq1_root);
            s2_side_reg <= sq1_side;

            s3_rem_reg  <= s2_num_reg[45:30];
            s3_low_reg  <= s2_num_reg[29:0];
            s3_side_reg <= s3_side_next;

            s4_sq_reg   <= 60'(dv_q_reg[DIV_STEPS-1]) * 60'(dv_q_reg[DIV_STEPS-1]);
            s4_side_reg <= dv_side_reg[DIV_STEPS-1];

            s5_rad_reg  <= (SQRT_RAD_W'(1) << 60) - SQRT_RAD_W'(s4_sq_reg);
            s5_side_reg <= s4_side_reg;

            s6_a_reg[0] <= PROD_W'(sq2_side.et) * PROD_W'(s6_ci);
            s6_a_reg[1] <= PROD_W'(sq2_side.ei) * PROD_W'(sq2_root);
            s6_a_reg[2] <= PROD_W'(sq2_side.ei) * PROD_W'(s6_ci);
            s6_a_reg[3] <= PROD_W'(sq2_side.et) * PROD_W'(sq2_root);
            s6_side_reg <= sq2_side;

            for (int l = 0; l < 2; l++)
            begin
                s7_n_reg[l] <= (s6_a_reg[2*l] >= s6_a_reg[2*l+1])
                             ? SUM_W'(s6_a_reg[2*l] - s6_a_reg[2*l+1])
                             : SUM_W'(s6_a_reg[2*l+1] - s6_a_reg[2*l]);
                s7_d_reg[l] <= SUM_W'(s6_a_reg[2*l]) + SUM_W'(s6_a_reg[2*l+1]);

                s8_r_reg[l]  <= (s7_n_reg[l] >= s7_d_reg[l]) ? s7_n_reg[l] - s7_d_reg[l]
                                                               : s7_n_reg[l];
                s8_q_reg[l]  <= {{(RAT_W-1){1'b0}}, s7_n_reg[l] >= s7_d_reg[l]};
                s8_d_reg[l]  <= s7_d_reg[l];
                s8_dz_reg[l] <= s7_d_reg[l] == '0;

                s9_sq_reg[l] <= SQ_W'(s9_amp[l]) * SQ_W'(s9_amp[l]);
            end
            s7_side_reg <= s6_side_reg;
            s8_side_reg <= s7_side_reg;
            s9_side_reg <= rt_side_reg[RAT_STEPS-1];

            s10_sum_reg <= ACC_W'(s9_sq_reg[0]) + ACC_W'(s9_sq_reg[1])
                         + (ACC_W'(1) << (60 - F));
            s10_tir_reg <= s9_side_reg.tir;

            reflectance_reg      <= s10_tir_reg ? REFL_ONE : refl_next;
            total_reflection_reg <= s10_tir_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign reflectance      = reflectance_reg;
    assign total_reflection = total_reflection_reg;

    `FDR_ASSERT_IMPL(a_tir_gives_one, out_valid && total_reflection, reflectance == REFL_ONE)
    `FDR_ASSERT_IMPL(a_refl_saturated, out_valid, reflectance <= REFL_ONE)
    `FDR_ASSERT_NEXT(a_pipe_frozen, out_valid && out_stall, $stable(s0_v_reg) && $stable(s10_v_reg))

endmodule
`default_nettype wire
